// ----- rtl/tgbc_pkg.sv -----
// Package for the tile grid box collision block: sizes, codes and the
// controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps

package tgbc_pkg;

  localparam int MAX_CELLS   = 4096;
  localparam int CELL_AW     = $clog2(MAX_CELLS);
  localparam int COORD_W     = 16;
  localparam int BOX_W       = 13;
  localparam int TS_W        = 9;
  localparam int MAP_W       = 7;
  localparam int DIVD_W      = COORD_W + 1;
  localparam int DIV_CW      = $clog2(DIVD_W + 1);
  localparam int PROD_W      = TS_W + MAP_W;
  localparam int NY_W        = 18;
  localparam int CLS_W       = 2;
  localparam int SNAP_MARGIN = 4;
  localparam int LADDER_LAST = 12;

  localparam logic [2:0] KIND_WRITE = 3'd0;
  localparam logic [2:0] KIND_POINT = 3'd1;
  localparam logic [2:0] KIND_LEFT  = 3'd2;
  localparam logic [2:0] KIND_RIGHT = 3'd3;
  localparam logic [2:0] KIND_DOWN  = 3'd4;
  localparam logic [2:0] KIND_UP    = 3'd5;

  localparam logic [CLS_W-1:0] CLS_AIR    = 2'd0;
  localparam logic [CLS_W-1:0] CLS_LADDER = 2'd1;
  localparam logic [CLS_W-1:0] CLS_SOLID  = 2'd2;
  localparam logic [CLS_W-1:0] CLS_BREAK  = 2'd3;

  localparam logic [1:0] REG_TILE_SIZE  = 2'd0;
  localparam logic [1:0] REG_MAP_WIDTH  = 2'd1;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd2;

  localparam logic [1:0] DIV_LAST = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_WRITE, ST_DIV_START, ST_DIV_WAIT,
    ST_SCAN_INIT, ST_ISSUE, ST_CHECK, ST_DONE
  } state_t;

  typedef struct packed {
    logic       clr_en;
    logic       load;
    logic       wr_cell;
    logic       div_start;
    logic [1:0] div_sel;
    logic       scan_init;
    logic       scan_issue;
    logic       scan_check;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       div_done;
    logic       scan_finish;
    logic [2:0] kind;
  } sts_t;

endpackage

// ----- rtl/tgbc_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on tgbc_pkg.
`timescale 1ns / 1ps

module tgbc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tgbc_pkg::DIVD_W-1:0] dividend,
  input  logic [tgbc_pkg::TS_W-1:0]   divisor,
  output logic                       busy,
  output logic                       done,
  output logic [tgbc_pkg::DIVD_W-1:0] quotient
);
  import tgbc_pkg::*;

  logic [DIVD_W-1:0] quot_r;
  logic [TS_W-1:0]   rem_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [TS_W:0]     rem_sh;
  logic [TS_W:0]     rem_diff;
  logic              ge;

  assign rem_sh   = {rem_r, quot_r[DIVD_W-1]};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign rem_diff = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CW'(DIVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
    end else if (busy_r) begin
      quot_r <= {quot_r[DIVD_W-2:0], ge};
      rem_r  <= ge ? rem_diff[TS_W-1:0] : rem_sh[TS_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quot_r;

endmodule

// ----- rtl/tgbc_dp.sv -----
// Datapath: item registers, class grid memory with clearing counter,
// divider, cell scan and result registers. Depends on tgbc_pkg, tgbc_div.
`timescale 1ns / 1ps

module tgbc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tgbc_pkg::cmd_t                cmd,
  output tgbc_pkg::sts_t                sts,
  input  logic [tgbc_pkg::TS_W-1:0]     tile_size,
  input  logic [tgbc_pkg::MAP_W-1:0]    map_width,
  input  logic [tgbc_pkg::MAP_W-1:0]    map_height,
  input  logic [2:0]                    in_kind,
  input  logic [tgbc_pkg::CELL_AW-1:0]  in_cell_index,
  input  logic [15:0]                   in_tile_number,
  input  logic                          in_mark_breakable,
  input  logic [tgbc_pkg::COORD_W-1:0]  in_pos_x,
  input  logic [tgbc_pkg::COORD_W-1:0]  in_pos_y,
  input  logic [tgbc_pkg::BOX_W-1:0]    in_box_w,
  input  logic [tgbc_pkg::BOX_W-1:0]    in_box_h,
  input  logic [tgbc_pkg::COORD_W-1:0]  in_cur_y,
  output logic                          out_hit,
  output logic signed [tgbc_pkg::NY_W-1:0] out_new_y,
  output logic [tgbc_pkg::CLS_W-1:0]    out_tile_class,
  output logic                          out_out_of_range
);
  import tgbc_pkg::*;

  logic [2:0]          kind_r;
  logic [CELL_AW-1:0]  cidx_r;
  logic [15:0]         tnum_r;
  logic                mark_r;
  logic [COORD_W-1:0]  px_r, py_r, cy_r;
  logic [BOX_W-1:0]    bw_r, bh_r;

  logic [DIVD_W-1:0]   q0_r, q1_r, q2_r;
  logic signed [DIVD_W:0] fixed_r;
  logic [DIVD_W-1:0]   cur_r, end_r;
  logic                insd_r, stop_r;
  logic [PROD_W-1:0]   prod_r;

  logic                res_hit_r, res_oor_r;
  logic [NY_W-1:0]     res_ny_r;
  logic [CLS_W-1:0]    res_cls_r;
  logic                o_hit_r, o_oor_r;
  logic [NY_W-1:0]     o_ny_r;
  logic [CLS_W-1:0]    o_cls_r;

  logic [CELL_AW-1:0]  clr_cnt_r;
  logic [CLS_W-1:0]    mem [MAX_CELLS];
  logic [CLS_W-1:0]    mem_q_r;

  logic [TS_W-1:0]     ts_eff;
  logic [DIVD_W-1:0]   sum_x, sum_y, dividend, quot;
  logic                div_busy, div_done;
  logic [CLS_W-1:0]    wr_cls;
  logic [2*MAP_W-1:0]  area;
  logic                wr_ok;
  logic                vert, horiz_pt;
  logic [DIVD_W:0]     col_s, row_u;
  logic                col_in, row_in, idx_in, cell_in, stop;
  logic [2*MAP_W:0]    idx;
  logic [CLS_W-1:0]    cls_c;
  logic                blk;
  logic signed [NY_W:0] snap_v;
  logic                snap_ok, hit_now, finish;

  assign ts_eff = (tile_size == '0) ? TS_W'(1) : tile_size;
  assign sum_x  = {1'b0, px_r} + {4'b0, bw_r} - DIVD_W'(1);
  assign sum_y  = {1'b0, py_r} + {4'b0, bh_r} - DIVD_W'(1);
  assign vert   = (kind_r == KIND_LEFT) || (kind_r == KIND_RIGHT);
  assign horiz_pt = (kind_r == KIND_POINT);

  always_comb begin
    dividend = {1'b0, px_r};
    case (cmd.div_sel)
      2'd0: begin
        case (kind_r)
          KIND_POINT: dividend = {1'b0, py_r};
          KIND_LEFT:  dividend = {1'b0, px_r};
          KIND_RIGHT: dividend = sum_x;
          KIND_DOWN:  dividend = sum_y;
          default:    dividend = {1'b0, py_r};
        endcase
      end
      2'd1: dividend = vert ? {1'b0, py_r} : {1'b0, px_r};
      default: begin
        if (vert) dividend = sum_y;
        else if (horiz_pt) dividend = {1'b0, px_r};
        else dividend = sum_x;
      end
    endcase
  end

  tgbc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (ts_eff),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    if (tnum_r == '0) wr_cls = CLS_AIR;
    else if (tnum_r <= 16'(LADDER_LAST)) wr_cls = CLS_LADDER;
    else wr_cls = mark_r ? CLS_BREAK : CLS_SOLID;
  end
  assign area  = map_width * map_height;
  assign wr_ok = {2'b0, cidx_r} < area;

  // cell address for the scan step
  assign col_s  = vert ? fixed_r : {1'b0, cur_r};
  assign row_u  = vert ? {1'b0, cur_r} : fixed_r;
  assign col_in = !col_s[DIVD_W] && (col_s[DIVD_W-1:0] < {10'b0, map_width});
  assign row_in = row_u[DIVD_W-1:0] < {10'b0, map_height};
  assign idx    = (2*MAP_W+1)'(row_u[MAP_W-1:0] * map_width) +
                  {8'b0, col_s[MAP_W-1:0]};
  assign idx_in = idx < (2*MAP_W+1)'(MAX_CELLS);
  assign cell_in = col_in && row_in && idx_in;
  assign stop   = vert ? !row_in : !col_in;

  assign cls_c   = insd_r ? mem_q_r : CLS_AIR;
  assign blk     = insd_r && mem_q_r[1];
  assign snap_v  = $signed({3'b0, cy_r}) - $signed({3'b0, prod_r}) +
                   $signed({6'b0, bh_r});
  assign snap_ok = snap_v <= (NY_W+1)'(SNAP_MARGIN);
  assign hit_now = blk && ((kind_r != KIND_DOWN) || snap_ok);
  assign finish  = horiz_pt || hit_now || (!insd_r && stop_r) || (cur_r == end_r);

  always_ff @(posedge clk) begin
    if (cmd.clr_en) mem[clr_cnt_r] <= CLS_AIR;
    else if (cmd.wr_cell && wr_ok) mem[cidx_r] <= wr_cls;
    mem_q_r <= mem[idx[CELL_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr_en) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      cidx_r    <= in_cell_index;
      tnum_r    <= in_tile_number;
      mark_r    <= in_mark_breakable;
      px_r      <= in_pos_x;
      py_r      <= in_pos_y;
      cy_r      <= in_cur_y;
      bw_r      <= (in_box_w == '0) ? BOX_W'(1) : in_box_w;
      bh_r      <= (in_box_h == '0) ? BOX_W'(1) : in_box_h;
      res_hit_r <= 1'b0;
      res_oor_r <= 1'b0;
      res_cls_r <= CLS_AIR;
      res_ny_r  <= {2'b0, in_cur_y};
    end
    if (cmd.wr_cell) begin
      res_cls_r <= wr_cls;
      res_oor_r <= !wr_ok;
    end
    if (div_done) begin
      case (cmd.div_sel)
        2'd0:    q0_r <= quot;
        2'd1:    q1_r <= quot;
        default: q2_r <= quot;
      endcase
    end
    if (cmd.scan_init) begin
      if (kind_r == KIND_LEFT) fixed_r <= $signed({1'b0, q0_r}) - (DIVD_W+1)'(1);
      else if (kind_r == KIND_RIGHT) fixed_r <= $signed({1'b0, q0_r}) + (DIVD_W+1)'(1);
      else fixed_r <= $signed({1'b0, q0_r});
      cur_r <= q1_r;
      end_r <= q2_r;
    end
    if (cmd.scan_issue) begin
      insd_r <= cell_in;
      stop_r <= stop;
      prod_r <= ts_eff * row_u[MAP_W-1:0];
    end
    if (cmd.scan_check) begin
      if (horiz_pt) begin
        res_cls_r <= cls_c;
        res_oor_r <= !insd_r;
      end else begin
        if (!insd_r) res_oor_r <= 1'b1;
        if (hit_now) begin
          res_hit_r <= 1'b1;
          if (kind_r == KIND_UP) res_ny_r <= {2'b0, prod_r} + {5'b0, bh_r};
          else if (kind_r == KIND_DOWN) res_ny_r <= {2'b0, prod_r} - {5'b0, bh_r};
        end
      end
      if (!finish) cur_r <= cur_r + 1'b1;
    end
    if (cmd.out_load) begin
      o_hit_r <= res_hit_r;
      o_ny_r  <= res_ny_r;
      o_cls_r <= res_cls_r;
      o_oor_r <= res_oor_r;
    end
  end

  assign sts.clr_last    = (clr_cnt_r == CELL_AW'(MAX_CELLS - 1));
  assign sts.div_done    = div_done;
  assign sts.scan_finish = finish;
  assign sts.kind        = kind_r;

  assign out_hit          = o_hit_r;
  assign out_new_y        = $signed(o_ny_r);
  assign out_tile_class   = o_cls_r;
  assign out_out_of_range = o_oor_r;

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy) else $error("divider restarted while busy");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_issue |-> cur_r <= end_r) else $error("scan ran past end");

endmodule

// ----- rtl/tgbc_ctrl.sv -----
// Controller state machine: grid clear, dispatch, divide sequence, cell scan
// and output handshake. Depends on tgbc_pkg.
`timescale 1ns / 1ps

module tgbc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output tgbc_pkg::cmd_t cmd,
  input  tgbc_pkg::sts_t sts
);
  import tgbc_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] div_sel_r, div_sel_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:     if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:      if (in_valid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        if (sts.kind == KIND_WRITE) state_nxt = ST_WRITE;
        else if (sts.kind inside {[KIND_POINT:KIND_UP]}) state_nxt = ST_DIV_START;
        else state_nxt = ST_DONE;
      end
      ST_WRITE:     state_nxt = ST_DONE;
      ST_DIV_START: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (sts.div_done) state_nxt = (div_sel_r == DIV_LAST) ? ST_SCAN_INIT : ST_DIV_START;
      end
      ST_SCAN_INIT: state_nxt = ST_ISSUE;
      ST_ISSUE:     state_nxt = ST_CHECK;
      ST_CHECK:     state_nxt = sts.scan_finish ? ST_DONE : ST_ISSUE;
      ST_DONE:      if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.div_sel    = div_sel_r;
    cmd.clr_en     = (state_r == ST_CLEAR);
    cmd.load       = (state_r == ST_IDLE) && in_valid;
    cmd.wr_cell    = (state_r == ST_WRITE);
    cmd.div_start  = (state_r == ST_DIV_START);
    cmd.scan_init  = (state_r == ST_SCAN_INIT);
    cmd.scan_issue = (state_r == ST_ISSUE);
    cmd.scan_check = (state_r == ST_CHECK);
    cmd.out_load   = (state_r == ST_DONE) && out_free;
    in_ready       = (state_r == ST_IDLE);
  end

  always_comb begin
    div_sel_nxt = div_sel_r;
    if (state_r == ST_DISPATCH) div_sel_nxt = '0;
    else if (state_r == ST_DIV_WAIT && sts.div_done) div_sel_nxt = div_sel_r + 1'b1;
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      div_sel_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_sel_r   <= div_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_issue_check: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ISSUE |=> state_r == ST_CHECK) else $error("issue not followed by check");
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE)) else $error("result raised outside done");

endmodule

// ----- rtl/tile_grid_box_collision.sv -----
// Top level of the tile grid box collision block: configuration registers
// on an APB-style port, controller and datapath. Depends on tgbc_pkg,
// tgbc_ctrl, tgbc_dp.
`timescale 1ns / 1ps

// Input transactions (in_valid/in_ready) carry a cell write or a query;
// each yields one result transaction on out_valid/out_ready.
// Registers: tile_size at 0x0, map_width at 0x4, map_height at 0x8, must be
// written only while the block is idle, which the block itself does not
// enforce; pready is always high. One item is taken at a time; in_ready is
// high only in the idle state. A write passes through a write state to the
// done state, an unknown kind goes straight to done, and a query runs three
// 17-bit serial divides by the tile size, then one memory read and one check
// per cell. After reset a clearing pass writes air into all 4096 grid cells,
// one per cycle; in_ready stays low until the pass is over.
// A finished result sits in the output register; the next item is taken
// while it waits, and that item holds in its done state until the
// receiver takes the earlier result.
module tile_grid_box_collision (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_kind,
  input  logic [tgbc_pkg::CELL_AW-1:0]  in_cell_index,
  input  logic [15:0]                   in_tile_number,
  input  logic                          in_mark_breakable,
  input  logic [tgbc_pkg::COORD_W-1:0]  in_pos_x,
  input  logic [tgbc_pkg::COORD_W-1:0]  in_pos_y,
  input  logic [tgbc_pkg::BOX_W-1:0]    in_box_w,
  input  logic [tgbc_pkg::BOX_W-1:0]    in_box_h,
  input  logic [tgbc_pkg::COORD_W-1:0]  in_cur_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic signed [tgbc_pkg::NY_W-1:0] out_new_y,
  output logic [tgbc_pkg::CLS_W-1:0]    out_tile_class,
  output logic                          out_out_of_range,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tgbc_pkg::*;

  logic [TS_W-1:0]  tile_size_r;
  logic [MAP_W-1:0] map_width_r, map_height_r;
  logic             wr_en;
  cmd_t             cmd;
  sts_t             sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_size_r  <= TS_W'(16);
      map_width_r  <= MAP_W'(32);
      map_height_r <= MAP_W'(32);
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_TILE_SIZE:  tile_size_r  <= pwdata[TS_W-1:0];
        REG_MAP_WIDTH:  map_width_r  <= pwdata[MAP_W-1:0];
        REG_MAP_HEIGHT: map_height_r <= pwdata[MAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TILE_SIZE:  prdata = {23'b0, tile_size_r};
      REG_MAP_WIDTH:  prdata = {25'b0, map_width_r};
      REG_MAP_HEIGHT: prdata = {25'b0, map_height_r};
      default:        prdata = '0;
    endcase
  end

  tgbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tgbc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .tile_size         (tile_size_r),
    .map_width         (map_width_r),
    .map_height        (map_height_r),
    .in_kind           (in_kind),
    .in_cell_index     (in_cell_index),
    .in_tile_number    (in_tile_number),
    .in_mark_breakable (in_mark_breakable),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_box_w          (in_box_w),
    .in_box_h          (in_box_h),
    .in_cur_y          (in_cur_y),
    .out_hit           (out_hit),
    .out_new_y         (out_new_y),
    .out_tile_class    (out_tile_class),
    .out_out_of_range  (out_out_of_range)
  );

endmodule

// ----- tb/tile_grid_box_collision_tb.sv -----
// Testbench for tile_grid_box_collision: directed table plus random cell writes and
// box queries, checked against an in-bench model of the class grid. Depends on tgbc_pkg.
`timescale 1ns / 1ps

module tile_grid_box_collision_tb;
  import tgbc_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] cidx;
    logic [15:0] tnum;
    logic        mark;
    logic [15:0] px;
    logic [15:0] py;
    logic [12:0] bw;
    logic [12:0] bh;
    logic [15:0] cy;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic signed [17:0] ny;
    logic [1:0]        cls;
    logic              oor;
  } rsp_t;

  typedef struct {
    req_t req;
    bit   known;
    rsp_t rsp;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_ready;
  req_t drv;
  logic out_valid, out_ready;
  logic out_hit, out_out_of_range;
  logic signed [17:0] out_new_y;
  logic [1:0] out_tile_class;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  tile_grid_box_collision i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(drv.kind), .in_cell_index(drv.cidx), .in_tile_number(drv.tnum),
    .in_mark_breakable(drv.mark), .in_pos_x(drv.px), .in_pos_y(drv.py),
    .in_box_w(drv.bw), .in_box_h(drv.bh), .in_cur_y(drv.cy),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit(out_hit), .out_new_y(out_new_y), .out_tile_class(out_tile_class),
    .out_out_of_range(out_out_of_range),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [1:0] grid_cls [MAX_CELLS];
  int unsigned cfg_tile, cfg_w, cfg_h;
  rsp_t collision_q [$];
  int errors, n_in, n_out, n_hits, n_oor;
  int snd_idle, rcv_idle;
  bit rcv_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic bit cell_read(longint col, longint row, output logic [1:0] c);
    c = CLS_AIR;
    if (col < 0 || row < 0) return 0;
    if (col >= cfg_w || row >= cfg_h) return 0;
    if (row * cfg_w + col >= MAX_CELLS) return 0;
    c = grid_cls[row * cfg_w + col];
    return 1;
  endfunction

  function automatic rsp_t collide(req_t r);
    rsp_t o;
    longint ts, bw, bh, px, py, cy, col, row, lo, hi, ny;
    logic [1:0] c;
    ts = (cfg_tile == 0) ? 1 : cfg_tile;
    bw = (r.bw == 0) ? 1 : r.bw;
    bh = (r.bh == 0) ? 1 : r.bh;
    px = r.px;
    py = r.py;
    cy = r.cy;
    ny = cy;
    o = '0;
    case (r.kind)
      KIND_WRITE: begin
        if (r.tnum == 0) o.cls = CLS_AIR;
        else if (r.tnum <= LADDER_LAST) o.cls = CLS_LADDER;
        else o.cls = r.mark ? CLS_BREAK : CLS_SOLID;
        if (r.cidx < cfg_w * cfg_h) grid_cls[r.cidx] = o.cls;
        else o.oor = 1'b1;
      end
      KIND_POINT: begin
        if (!cell_read(px / ts, py / ts, c)) o.oor = 1'b1;
        o.cls = c;
      end
      KIND_LEFT, KIND_RIGHT: begin
        col = (r.kind == KIND_LEFT) ? px / ts - 1 : (px + bw - 1) / ts + 1;
        lo = py / ts;
        hi = (py + bh - 1) / ts;
        for (row = lo; row <= hi; row++) begin
          if (!cell_read(col, row, c)) begin
            o.oor = 1'b1;
            if (row >= cfg_h) break;
            continue;
          end
          if (c[1]) begin
            o.hit = 1'b1;
            break;
          end
        end
      end
      KIND_DOWN, KIND_UP: begin
        row = (r.kind == KIND_DOWN) ? (py + bh - 1) / ts : py / ts;
        lo = px / ts;
        hi = (px + bw - 1) / ts;
        for (col = lo; col <= hi; col++) begin
          if (!cell_read(col, row, c)) begin
            o.oor = 1'b1;
            if (col >= cfg_w) break;
            continue;
          end
          if (!c[1]) continue;
          if (r.kind == KIND_UP) begin
            ny = ts * row + bh;
            o.hit = 1'b1;
            break;
          end
          if (cy - ts * row + bh <= SNAP_MARGIN) begin
            ny = ts * row - bh;
            o.hit = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    o.ny = ny[17:0];
    return o;
  endfunction

  task automatic cfg_write(logic [1:0] idx, int unsigned val);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_TILE_SIZE: cfg_tile = val & 32'h1FF;
      REG_MAP_WIDTH: cfg_w = val & 32'h7F;
      default: cfg_h = val & 32'h7F;
    endcase
  endtask

  task automatic send_item(req_t r, bit known, rsp_t exp_rsp);
    rsp_t p;
    while ($urandom_range(99) < snd_idle) @(negedge clk);
    p = collide(r);
    if (known && p !== exp_rsp) begin
      $display("%0t table row disagrees with model: expected %h model %h", $time, exp_rsp, p);
      errors++;
    end
    drv = r;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (known) p = exp_rsp;
    collision_q = {collision_q, p};
    n_in++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (collision_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (300) @(posedge clk);
  endtask

  function automatic req_t rand_req(bit small_map);
    req_t r;
    int unsigned span;
    r.kind = ($urandom_range(9) < 3) ? KIND_WRITE : 3'($urandom_range(1, 7) % 6);
    if ($urandom_range(29) == 0) r.kind = 3'($urandom_range(6, 7));
    span = cfg_w * cfg_h;
    r.cidx = ($urandom_range(9) == 0 || span == 0) ? 12'($urandom) :
             12'($urandom_range(span - 1));
    r.tnum = ($urandom_range(1)) ? 16'($urandom_range(20)) : 16'($urandom);
    r.mark = 1'($urandom);
    if (small_map && $urandom_range(7) != 0) begin
      r.px = 16'($urandom_range(cfg_w * cfg_tile + cfg_tile));
      r.py = 16'($urandom_range(cfg_h * cfg_tile + cfg_tile));
      r.bw = 13'($urandom_range(3 * cfg_tile));
      r.bh = 13'($urandom_range(3 * cfg_tile));
      r.cy = 16'(r.py + $urandom_range(8));
    end else begin
      r.px = 16'($urandom);
      r.py = 16'($urandom);
      r.bw = ($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(64));
      r.bh = ($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(64));
      r.cy = 16'($urandom);
    end
    return r;
  endfunction

  // result side
  always @(negedge clk) begin
    if (!rst_n || rcv_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    rsp_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_hit, out_new_y, out_tile_class, out_out_of_range};
      n_out++;
      if (got.hit) n_hits++;
      if (got.oor) n_oor++;
      if (collision_q.size() == 0) begin
        $display("%0t unexpected transaction: actual %h", $time, got);
        errors++;
      end else begin
        want = collision_q.pop_front();
        if (got.hit !== want.hit || got.ny !== want.ny || got.cls !== want.cls ||
            got.oor !== want.oor) begin
          $display("%0t mismatch: expected hit %0d y %0d cls %0d oor %0d, actual hit %0d y %0d cls %0d oor %0d",
                   $time, want.hit, want.ny, want.cls, want.oor,
                   got.hit, got.ny, got.cls, got.oor);
          errors++;
        end
      end
    end
  end

  function automatic req_t mk(logic [2:0] k, int ci, int tn, bit m, int x, int y,
                              int w, int h, int c);
    req_t r;
    r = '{k, 12'(ci), 16'(tn), m, 16'(x), 16'(y), 13'(w), 13'(h), 16'(c)};
    return r;
  endfunction

  function automatic rsp_t rs(bit h, int y, int c, bit o);
    rsp_t r;
    r = '{h, 18'(y), 2'(c), o};
    return r;
  endfunction

  row_t dir_tab [$];

  initial begin
    int phase, k;
    rsp_t nr;
    errors = 0; n_in = 0; n_out = 0; n_hits = 0; n_oor = 0;
    rst_n = 1'b0; in_valid = 1'b0; drv = '0; rcv_hold = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    snd_idle = 13; rcv_idle = 48;
    cfg_tile = 16; cfg_w = 32; cfg_h = 32;
    foreach (grid_cls[i]) grid_cls[i] = CLS_AIR;
    nr = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // reset grid is all air; writes at the class boundaries
    dir_tab = '{
      '{mk(KIND_POINT, 0, 0, 0, 0, 0, 1, 1, 7), 1, rs(0, 7, CLS_AIR, 0)},
      '{mk(KIND_POINT, 0, 0, 0, 65535, 65535, 1, 1, 65535), 1, rs(0, 65535, CLS_AIR, 1)},
      '{mk(KIND_WRITE, 0, 0, 1, 0, 0, 1, 1, 3), 1, rs(0, 3, CLS_AIR, 0)},
      '{mk(KIND_WRITE, 1, 1, 0, 0, 0, 1, 1, 0), 1, rs(0, 0, CLS_LADDER, 0)},
      '{mk(KIND_WRITE, 2, 12, 1, 0, 0, 1, 1, 0), 1, rs(0, 0, CLS_LADDER, 0)},
      '{mk(KIND_WRITE, 3, 13, 0, 0, 0, 1, 1, 0), 1, rs(0, 0, CLS_SOLID, 0)},
      '{mk(KIND_WRITE, 4, 65535, 1, 0, 0, 1, 1, 0), 1, rs(0, 0, CLS_BREAK, 0)},
      '{mk(KIND_WRITE, 4095, 20, 0, 0, 0, 1, 1, 0), 1, rs(0, 0, CLS_SOLID, 1)},
      '{mk(KIND_WRITE, 33, 20, 0, 0, 0, 1, 1, 0), 1, rs(0, 0, CLS_SOLID, 0)},
      '{mk(KIND_WRITE, 66, 20, 1, 0, 0, 1, 1, 0), 1, rs(0, 0, CLS_BREAK, 0)},
      '{mk(KIND_POINT, 0, 0, 0, 48, 0, 1, 1, 0), 1, rs(0, 0, CLS_SOLID, 0)},
      '{mk(KIND_LEFT, 0, 0, 0, 0, 0, 16, 16, 0), 1, rs(0, 0, CLS_AIR, 1)},
      '{mk(KIND_LEFT, 0, 0, 0, 64, 0, 16, 16, 0), 0, nr},
      '{mk(KIND_RIGHT, 0, 0, 0, 0, 16, 16, 16, 0), 0, nr},
      '{mk(KIND_RIGHT, 0, 0, 0, 65535, 65535, 8191, 8191, 0), 0, nr},
      '{mk(KIND_DOWN, 0, 0, 0, 16, 8, 8, 8, 8), 0, nr},
      '{mk(KIND_DOWN, 0, 0, 0, 16, 0, 8, 8, 0), 0, nr},
      '{mk(KIND_UP, 0, 0, 0, 32, 32, 16, 16, 40), 0, nr},
      '{mk(KIND_UP, 0, 0, 0, 65535, 0, 0, 0, 0), 0, nr},
      '{mk(KIND_DOWN, 0, 0, 0, 0, 65535, 4096, 4096, 65535), 0, nr},
      '{mk(3'd6, 0, 0, 0, 0, 0, 1, 1, 9), 1, rs(0, 9, CLS_AIR, 0)},
      '{mk(3'd7, 4095, 65535, 1, 65535, 65535, 8191, 8191, 65535), 1, rs(0, 65535, CLS_AIR, 0)}
    };
    foreach (dir_tab[i]) send_item(dir_tab[i].req, dir_tab[i].known, dir_tab[i].rsp);
    drain();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin cfg_write(REG_TILE_SIZE, 256); cfg_write(REG_MAP_WIDTH, 64);
                 cfg_write(REG_MAP_HEIGHT, 64); end
        1: begin cfg_write(REG_TILE_SIZE, 1); cfg_write(REG_MAP_WIDTH, 1);
                 cfg_write(REG_MAP_HEIGHT, 1); end
        2: begin cfg_write(REG_TILE_SIZE, 0); cfg_write(REG_MAP_WIDTH, 7);
                 cfg_write(REG_MAP_HEIGHT, 5); snd_idle = 48; rcv_idle = 13; end
        3: begin cfg_write(REG_TILE_SIZE, 8); cfg_write(REG_MAP_WIDTH, 12);
                 cfg_write(REG_MAP_HEIGHT, 9); end
        4: begin cfg_write(REG_TILE_SIZE, 511); cfg_write(REG_MAP_WIDTH, 127);
                 cfg_write(REG_MAP_HEIGHT, 127); snd_idle = 0; rcv_idle = 0; end
        default: begin cfg_write(REG_TILE_SIZE, 16); cfg_write(REG_MAP_WIDTH, 64);
                 cfg_write(REG_MAP_HEIGHT, 0); end
      endcase
      for (k = 0; k < 150; k++) begin
        if (phase == 4 && k == 20) begin
          rcv_hold = 1'b1;
          fork
            begin
              repeat (400) @(posedge clk);
              rcv_hold = 1'b0;
            end
          join_none
        end
        send_item(rand_req(phase != 4 || k[0]), 0, nr);
      end
      drain();
    end

    $display("covered %0d items, %0d results, %0d hits, %0d out-of-grid flags",
             n_in, n_out, n_hits, n_oor);
    $display("over six grid/tile settings including size extremes and a long output stall");
    if (errors == 0 && collision_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- tile_grid_box_collision.f -----
rtl/tgbc_pkg.sv
rtl/tgbc_div.sv
rtl/tgbc_dp.sv
rtl/tgbc_ctrl.sv
rtl/tile_grid_box_collision.sv
tb/tile_grid_box_collision_tb.sv
